// File: rtl/core/erq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the retirement queue.
package erq_pkg;

	// Default sizing
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int HANDLE_BITS_DEF = 32;
	localparam int EPOCH_BITS_DEF  = 32;

	// Fixed field widths
	localparam int OPCODE_W    = 3;
	localparam int ACTION_W    = 8;
	localparam int COOKIE_W    = 16;
	localparam int STATUS_W    = 2;
	localparam int CAP_W       = 7;
	localparam int DEPTH_OUT_W = 7;
	localparam int REFUSE_W    = 32;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	// Capacity register reset value
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Register word index
	localparam logic REG_QUEUE_CAPACITY = 1'b0;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_RETIRE      = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADVANCE     = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_COMPLETE    = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_RECLAIM     = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_RECLAIM_ALL = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_INVAL = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;   // latch the incoming request
		logic exec;     // run a single-result operation
		logic pop;      // take the head entry into the pending slot
		logic finish;   // close a drain with its final result
	} erq_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_drain;    // latched opcode is a reclaim
		logic elig;        // head entry may be drained now
		logic pend_valid;  // a drained entry waits in the pending slot
		logic out_free;    // output register can take a result this cycle
	} erq_sts_t;

endpackage

// File: rtl/core/epoch_retirement_queue_unit.sv
// Epoch retirement queue: a deferred-reclamation FIFO whose entries are released
// once the completed epoch reaches the epoch they were retired in (a reclaim-all
// releases every entry). Retire, advance, complete and unknown requests pass
// through accept, then execute, and give one result; the execute step waits while
// an earlier result is still held in the output register. A reclaim passes
// through accept, decode, a drain step for each entry and a closing step (at least
// one result is always given): the slot memory has a single registered read port,
// so the drain releases one entry per cycle while the output side does not stall.
// The output register lets a new request be accepted while a result still waits.
// Slot contents are not cleared at reset; only written slots are ever read.
// queue_capacity sits at byte address 0 of the APB port and resets to 64.
module epoch_retirement_queue_unit #(
	parameter int QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = erq_pkg::HANDLE_BITS_DEF,
	parameter int EPOCH_BITS  = erq_pkg::EPOCH_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [erq_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [erq_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [erq_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [erq_pkg::OPCODE_W-1:0]    opcode,
	input  logic [HANDLE_BITS-1:0]          resource_handle,
	input  logic [erq_pkg::ACTION_W-1:0]    reclaim_action,
	input  logic [erq_pkg::COOKIE_W-1:0]    user_cookie,
	input  logic [EPOCH_BITS-1:0]           epoch_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [erq_pkg::STATUS_W-1:0]    status,
	output logic                            last,
	output logic                            entry_valid,
	output logic [HANDLE_BITS-1:0]          out_handle,
	output logic [erq_pkg::ACTION_W-1:0]    out_action,
	output logic [erq_pkg::COOKIE_W-1:0]    out_cookie,
	output logic [EPOCH_BITS-1:0]           entry_epoch,
	output logic [EPOCH_BITS-1:0]           current_epoch,
	output logic [EPOCH_BITS-1:0]           completed_epoch,
	output logic [erq_pkg::DEPTH_OUT_W-1:0] queue_depth,
	output logic [EPOCH_BITS-1:0]           stall_count,
	output logic [erq_pkg::REFUSE_W-1:0]    refused_count
);
	import erq_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             reg_sel;
	erq_cmd_t         cmd;
	erq_sts_t         sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	// Capacity register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready &&
		             (reg_sel == REG_QUEUE_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// Register read back
	assign prdata = (reg_sel == REG_QUEUE_CAPACITY) ? APB_DATA_W'(capacity_q) : '0;

	erq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	erq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS),
		.EPOCH_BITS  (EPOCH_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.capacity        (capacity_q),
		.opcode          (opcode),
		.resource_handle (resource_handle),
		.reclaim_action  (reclaim_action),
		.user_cookie     (user_cookie),
		.epoch_value     (epoch_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.last            (last),
		.entry_valid     (entry_valid),
		.out_handle      (out_handle),
		.out_action      (out_action),
		.out_cookie      (out_cookie),
		.entry_epoch     (entry_epoch),
		.current_epoch   (current_epoch),
		.completed_epoch (completed_epoch),
		.queue_depth     (queue_depth),
		.stall_count     (stall_count),
		.refused_count   (refused_count)
	);

endmodule

// File: rtl/core/erq_ctrl.sv
// Controller state machine that sequences request execution and queue drains.
module erq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  erq_pkg::erq_sts_t sts,
	output erq_pkg::erq_cmd_t cmd
);
	import erq_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and command decode
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_drain) begin
					state_d = ST_CHECK;
				end else if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_CHECK: begin
				if (sts.elig) begin
					if (!sts.pend_valid || sts.out_free) begin
						cmd.pop = 1'b1;
					end
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/erq_dpath.sv
// Datapath: slot memory, queue pointers, epoch registers and result register.
module erq_dpath #(
	parameter int QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = erq_pkg::HANDLE_BITS_DEF,
	parameter int EPOCH_BITS  = erq_pkg::EPOCH_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  erq_pkg::erq_cmd_t               cmd,
	output erq_pkg::erq_sts_t               sts,
	input  logic [erq_pkg::CAP_W-1:0]       capacity,
	input  logic [erq_pkg::OPCODE_W-1:0]    opcode,
	input  logic [HANDLE_BITS-1:0]          resource_handle,
	input  logic [erq_pkg::ACTION_W-1:0]    reclaim_action,
	input  logic [erq_pkg::COOKIE_W-1:0]    user_cookie,
	input  logic [EPOCH_BITS-1:0]           epoch_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [erq_pkg::STATUS_W-1:0]    status,
	output logic                            last,
	output logic                            entry_valid,
	output logic [HANDLE_BITS-1:0]          out_handle,
	output logic [erq_pkg::ACTION_W-1:0]    out_action,
	output logic [erq_pkg::COOKIE_W-1:0]    out_cookie,
	output logic [EPOCH_BITS-1:0]           entry_epoch,
	output logic [EPOCH_BITS-1:0]           current_epoch,
	output logic [EPOCH_BITS-1:0]           completed_epoch,
	output logic [erq_pkg::DEPTH_OUT_W-1:0] queue_depth,
	output logic [EPOCH_BITS-1:0]           stall_count,
	output logic [erq_pkg::REFUSE_W-1:0]    refused_count
);
	import erq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);

	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle;
		logic [ACTION_W-1:0]    action;
		logic [COOKIE_W-1:0]    cookie;
		logic [EPOCH_BITS-1:0]  epoch;
	} slot_t;

	function automatic logic [EPOCH_BITS-1:0] stall_of(
		input logic                  nonempty,
		input logic [EPOCH_BITS-1:0] now,
		input logic [EPOCH_BITS-1:0] moved
	);
		logic [EPOCH_BITS-1:0] diff;
		diff = now - moved;
		return (nonempty && (now > moved)) ? diff : '0;
	endfunction

	// Latched request
	logic [OPCODE_W-1:0]    op_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [ACTION_W-1:0]    action_q;
	logic [COOKIE_W-1:0]    cookie_q;
	logic [EPOCH_BITS-1:0]  ev_q;

	// Queue and epoch state
	slot_t                  mem_q [QUEUE_DEPTH];
	slot_t                  rd_q;
	logic [PTR_W-1:0]       head_q;
	logic [PTR_W-1:0]       tail_q;
	logic [CNT_W-1:0]       count_q;
	logic [EPOCH_BITS-1:0]  now_q;
	logic [EPOCH_BITS-1:0]  done_q;
	logic [EPOCH_BITS-1:0]  moved_q;
	logic [REFUSE_W-1:0]    refused_q;

	// Pending drained entry
	slot_t                  pend_q;
	logic [CNT_W-1:0]       pend_depth_q;
	logic                   pend_valid_q;

	// Result register
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   last_q;
	logic                   entry_valid_q;
	slot_t                  res_q;
	logic [EPOCH_BITS-1:0]  cur_q;
	logic [EPOCH_BITS-1:0]  cdone_q;
	logic [CNT_W-1:0]       depth_q;
	logic [EPOCH_BITS-1:0]  stall_q;
	logic [REFUSE_W-1:0]    refused_out_q;

	// Next-state and result logic
	logic [PTR_W-1:0]      head_inc;
	logic [PTR_W-1:0]      tail_inc;
	logic [PTR_W-1:0]      rd_addr;
	logic [CMP_W-1:0]      cap_ext;
	logic                  full;
	logic                  wr_en;
	slot_t                 wr_data;
	logic [CNT_W-1:0]      n_count;
	logic [EPOCH_BITS-1:0] n_now;
	logic [EPOCH_BITS-1:0] n_done;
	logic [EPOCH_BITS-1:0] n_moved;
	logic [REFUSE_W-1:0]   n_refused;
	logic                  load_out;
	logic [STATUS_W-1:0]   o_status;
	logic                  o_last;
	logic                  o_entry_valid;
	slot_t                 o_res;
	logic [CNT_W-1:0]      o_depth;

	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign rd_addr  = cmd.pop ? head_inc : head_q;

	// Effective capacity, clipped to the memory depth
	assign cap_ext = (CMP_W'(capacity) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(capacity);
	assign full    = (CMP_W'(count_q) >= cap_ext);

	// Status toward the controller
	assign sts.is_drain   = (op_q == OP_RECLAIM) || (op_q == OP_RECLAIM_ALL);
	assign sts.elig       = (count_q != '0) &&
	                        ((op_q == OP_RECLAIM_ALL) || (rd_q.epoch <= done_q));
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	// Execute single-result operations and select the next result
	always_comb begin
		wr_en         = 1'b0;
		wr_data       = '{handle: handle_q, action: action_q, cookie: cookie_q, epoch: now_q};
		n_count       = count_q;
		n_now         = now_q;
		n_done        = done_q;
		n_moved       = moved_q;
		n_refused     = refused_q;
		load_out      = 1'b0;
		o_status      = STS_OK;
		o_last        = 1'b1;
		o_entry_valid = 1'b0;
		o_res         = '0;
		o_depth       = count_q;
		if (cmd.exec) begin
			load_out = 1'b1;
			case (op_q)
				OP_RETIRE: begin
					if (action_q == '0) begin
						o_status = STS_INVAL;
					end else if (full) begin
						o_status = STS_FULL;
						if (refused_q != '1) begin
							n_refused = refused_q + 1'b1;
						end
					end else begin
						wr_en       = 1'b1;
						n_count     = count_q + 1'b1;
						o_res.epoch = now_q;
					end
				end
				OP_ADVANCE: begin
					if (now_q != '1) begin
						n_now = now_q + 1'b1;
					end
				end
				OP_COMPLETE: begin
					if (ev_q > done_q) begin
						n_done  = ev_q;
						n_moved = now_q;
					end
				end
				default: begin
					o_status = STS_INVAL;
				end
			endcase
			o_depth = n_count;
		end else if (pend_valid_q && (cmd.pop || cmd.finish)) begin
			load_out      = 1'b1;
			o_last        = cmd.finish;
			o_entry_valid = 1'b1;
			o_res         = pend_q;
			o_depth       = pend_depth_q;
		end else if (cmd.finish) begin
			load_out = 1'b1;
		end
		if (cmd.pop) begin
			n_count = count_q - 1'b1;
		end
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[tail_q] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// Latch the request payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= opcode;
			handle_q <= resource_handle;
			action_q <= reclaim_action;
			cookie_q <= user_cookie;
			ev_q     <= epoch_value;
		end
	end

	// Queue pointers, epochs and refusal counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			now_q     <= '0;
			done_q    <= '0;
			moved_q   <= '0;
			refused_q <= '0;
		end else begin
			count_q   <= n_count;
			now_q     <= n_now;
			done_q    <= n_done;
			moved_q   <= n_moved;
			refused_q <= n_refused;
			if (wr_en) begin
				tail_q <= tail_inc;
			end
			if (cmd.pop) begin
				head_q <= head_inc;
			end
		end
	end

	// Hold the last drained entry until its successor decides its last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.finish) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			pend_q       <= rd_q;
			pend_depth_q <= n_count;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q      <= o_status;
			last_q        <= o_last;
			entry_valid_q <= o_entry_valid;
			res_q         <= o_res;
			cur_q         <= n_now;
			cdone_q       <= n_done;
			depth_q       <= o_depth;
			stall_q       <= stall_of(o_depth != '0, n_now, n_moved);
			refused_out_q <= n_refused;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign last            = last_q;
	assign entry_valid     = entry_valid_q;
	assign out_handle      = res_q.handle;
	assign out_action      = res_q.action;
	assign out_cookie      = res_q.cookie;
	assign entry_epoch     = res_q.epoch;
	assign current_epoch   = cur_q;
	assign completed_epoch = cdone_q;
	assign queue_depth     = DEPTH_OUT_W'(depth_q);
	assign stall_count     = stall_q;
	assign refused_count   = refused_out_q;

endmodule

// File: rtl/core/erq_checker.sv
// Port-level checker for the retirement queue and its bind to the top level.
module erq_checker #(
	parameter int EPOCH_BITS = erq_pkg::EPOCH_BITS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [erq_pkg::STATUS_W-1:0]    status,
	input logic                            last,
	input logic                            entry_valid,
	input logic [erq_pkg::DEPTH_OUT_W-1:0] queue_depth,
	input logic [EPOCH_BITS-1:0]           stall_count
);
	import erq_pkg::*;

	// Hold a result until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// Only drained entries may be followed by more results of the same request
	a_not_last_is_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> entry_valid)
		else $error("non-final result carries no entry");

	// Refused or invalid requests give a single empty result
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STS_OK) |-> last && !entry_valid)
		else $error("error result is not a single empty result");

	// An empty queue reports no stall
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (queue_depth == '0) |-> (stall_count == '0))
		else $error("stall reported on empty queue");

endmodule

bind epoch_retirement_queue_unit erq_checker #(
	.EPOCH_BITS (EPOCH_BITS)
) u_erq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.last        (last),
	.entry_valid (entry_valid),
	.queue_depth (queue_depth),
	.stall_count (stall_count)
);
